// File: hdl/ffha_pkg.sv
`timescale 1ns / 1ps
package ffha_pkg;

  localparam int ADDR_W     = 28;
  localparam int SIZE_W     = 24;
  localparam int PAGE_W     = 17;
  localparam int HDR_BYTES  = 24;
  localparam int PAGE_SHIFT = 12;
  localparam int SPLIT_MIN  = HDR_BYTES + 8;
  localparam int SPAN_PAGES = 1 << (ADDR_W - PAGE_SHIFT);
  localparam logic [PAGE_W-1:0] LIMIT_RESET = PAGE_W'(256);

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FAIL    = 2'd1;
  localparam logic [1:0] ST_UNKNOWN = 2'd2;

  typedef struct packed {
    logic              req_type;
    logic [SIZE_W-1:0] req_size;
    logic [ADDR_W-1:0] payload_offset;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] result_offset;
    logic [1:0]        status;
  } rsp_t;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] size;
    logic              free;
  } ent_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_READ, OP_NEXT, OP_LATCH, OP_GROW, OP_DECIDE,
    OP_SH_READ, OP_SH_WRITE, OP_SPLIT, OP_TAKE, OP_MARK, OP_MERGE,
    OP_MFIN, OP_SET_RES, OP_PUSH
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] status;
  } cmd_t;

  typedef struct packed {
    logic is_free;
    logic zero_size;
    logic null_free;
    logic at_end;
    logic fit;
    logic addr_hit;
    logic grow_ok;
    logic grow_short;
    logic split;
    logic shift_done;
    logic out_busy;
  } flags_t;

endpackage

// File: hdl/ffha_datapath.sv
`timescale 1ns / 1ps
module ffha_datapath #(
  parameter int MAX_BLOCKS = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  input  ffha_pkg::req_t          req,
  input  logic                    cfg_we,
  input  logic [ffha_pkg::PAGE_W-1:0] cfg_data,
  input  ffha_pkg::cmd_t          cmd,
  output ffha_pkg::flags_t        flags,
  output logic                    out_valid,
  input  logic                    out_ready,
  output ffha_pkg::rsp_t          out_data
);
  import ffha_pkg::*;

  localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam logic [CW-1:0] MAX_C = CW'(MAX_BLOCKS);

  ent_t mem [MAX_BLOCKS];
  ent_t rdata;
  logic we;
  logic re;
  logic [IW-1:0] waddr;
  logic [IW-1:0] raddr;
  ent_t wdata;

  req_t              rq;
  logic [SIZE_W:0]   asize;
  logic [CW-1:0]     idx;
  logic [CW-1:0]     count;
  logic [CW-1:0]     k;
  logic [CW-1:0]     n;
  logic [CW-1:0]     fidx;
  logic [PAGE_W-1:0] heap_pages;
  logic [PAGE_W-1:0] limit;
  ent_t              ent;
  ent_t              cur;
  logic              split;
  rsp_t              res;

  logic [SIZE_W:0]   asize_next;
  logic [SIZE_W+2:0] total_up;
  logic [SIZE_W+2-PAGE_SHIFT:0] pages;
  logic [PAGE_W:0]   new_pages;
  logic [ADDR_W-1:0] rem;
  ent_t              grow_ent;
  ent_t              split_ent;
  ent_t              mrg;
  logic              mrg_join;

  assign asize_next = (SIZE_W+1)'(req.req_size) + (SIZE_W+1)'(7);
  assign total_up   = (SIZE_W+3)'(asize) + (SIZE_W+3)'(HDR_BYTES + (1 << PAGE_SHIFT) - 1);
  assign pages      = total_up[SIZE_W+2:PAGE_SHIFT];
  assign new_pages  = (PAGE_W+1)'(heap_pages) + (PAGE_W+1)'(pages);
  assign rem        = ent.size - ADDR_W'(asize);

  always_comb begin
    grow_ent.start = ADDR_W'(heap_pages) << PAGE_SHIFT;
    grow_ent.size  = (ADDR_W'(pages) << PAGE_SHIFT) - ADDR_W'(HDR_BYTES);
    grow_ent.free  = 1'b1;
    split_ent.start = ent.start + ADDR_W'(HDR_BYTES) + ADDR_W'(asize);
    split_ent.size  = rem - ADDR_W'(HDR_BYTES);
    split_ent.free  = 1'b1;
    mrg = rdata;
    if (idx == fidx) begin
      mrg.free = 1'b1;
    end
    mrg_join = (n != '0) && cur.free && mrg.free;
  end

  always_comb begin
    flags.is_free    = (rq.req_type == REQ_FREE);
    flags.zero_size  = (rq.req_size == '0);
    flags.null_free  = (rq.payload_offset == '0);
    flags.at_end     = (idx == count);
    flags.fit        = rdata.free && (rdata.size >= ADDR_W'(asize));
    flags.addr_hit   = (ADDR_W'(rdata.start + ADDR_W'(HDR_BYTES)) == rq.payload_offset);
    flags.grow_ok    = (count < MAX_C) && (new_pages <= (PAGE_W+1)'(limit))
                       && (new_pages <= (PAGE_W+1)'(SPAN_PAGES));
    flags.grow_short = (ent.size < ADDR_W'(asize));
    flags.split      = split;
    flags.shift_done = (k == idx + CW'(1));
    flags.out_busy   = out_valid && !out_ready;
  end

  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    waddr = idx[IW-1:0];
    raddr = idx[IW-1:0];
    wdata = ent;
    unique case (cmd.op)
      OP_READ:     re = 1'b1;
      OP_GROW: begin
        we    = 1'b1;
        waddr = count[IW-1:0];
        wdata = grow_ent;
      end
      OP_SH_READ: begin
        re    = 1'b1;
        raddr = IW'(k - CW'(1));
      end
      OP_SH_WRITE: begin
        we    = 1'b1;
        waddr = k[IW-1:0];
        wdata = rdata;
      end
      OP_SPLIT: begin
        we    = 1'b1;
        waddr = IW'(idx + CW'(1));
        wdata = split_ent;
      end
      OP_TAKE: begin
        we         = 1'b1;
        wdata.free = 1'b0;
        if (split) begin
          wdata.size = ADDR_W'(asize);
        end
      end
      OP_MERGE: begin
        we    = !mrg_join && (n != '0);
        waddr = IW'(n - CW'(1));
        wdata = cur;
      end
      OP_MFIN: begin
        we    = 1'b1;
        waddr = IW'(n - CW'(1));
        wdata = cur;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cfg_we) begin
      limit <= cfg_data;
    end
    unique case (cmd.op)
      OP_LOAD: begin
        rq    <= req;
        asize <= {asize_next[SIZE_W:3], 3'b000};
        idx   <= '0;
      end
      OP_NEXT:   idx <= idx + CW'(1);
      OP_LATCH:  ent <= rdata;
      OP_GROW: begin
        ent        <= grow_ent;
        idx        <= count;
        count      <= count + CW'(1);
        heap_pages <= new_pages[PAGE_W-1:0];
      end
      OP_DECIDE: begin
        split <= (rem > ADDR_W'(SPLIT_MIN)) && (count < MAX_C);
        k     <= count;
      end
      OP_SH_WRITE: k <= k - CW'(1);
      OP_SPLIT:    count <= count + CW'(1);
      OP_TAKE: begin
        res.result_offset <= ent.start + ADDR_W'(HDR_BYTES);
        res.status        <= ST_OK;
      end
      OP_MARK: begin
        fidx <= idx;
        idx  <= '0;
        n    <= '0;
      end
      OP_MERGE: begin
        if (mrg_join) begin
          cur.size <= cur.size + ADDR_W'(HDR_BYTES) + mrg.size;
        end else begin
          cur <= mrg;
          n   <= n + CW'(1);
        end
        idx <= idx + CW'(1);
      end
      OP_MFIN: begin
        count             <= n;
        res.result_offset <= '0;
        res.status        <= ST_OK;
      end
      OP_SET_RES: begin
        res.result_offset <= '0;
        res.status        <= cmd.status;
      end
      OP_PUSH:  out_data <= res;
      default: ;
    endcase
    if (rst) begin
      count      <= '0;
      heap_pages <= '0;
      limit      <= LIMIT_RESET;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == OP_PUSH) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// File: hdl/ffha_ctrl.sv
`timescale 1ns / 1ps
module ffha_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  ffha_pkg::flags_t flags,
  output ffha_pkg::cmd_t   cmd
);
  import ffha_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_A_RD, S_A_EV, S_GROW, S_G_CHK, S_TAKE, S_SH_CHK,
    S_SH_WR, S_SPLIT, S_WTAKE, S_F_RD, S_F_EV, S_M_RD, S_M_EV, S_M_FIN, S_RESP
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    cmd.status = ST_OK;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (flags.is_free) begin
          if (flags.null_free) begin
            cmd.op     = OP_SET_RES;
            state_next = S_RESP;
          end else begin
            state_next = S_F_RD;
          end
        end else if (flags.zero_size) begin
          cmd.op     = OP_SET_RES;
          cmd.status = ST_FAIL;
          state_next = S_RESP;
        end else begin
          state_next = S_A_RD;
        end
      end
      S_A_RD: begin
        if (flags.at_end) begin
          state_next = S_GROW;
        end else begin
          cmd.op     = OP_READ;
          state_next = S_A_EV;
        end
      end
      S_A_EV: begin
        if (flags.fit) begin
          cmd.op     = OP_LATCH;
          state_next = S_TAKE;
        end else begin
          cmd.op     = OP_NEXT;
          state_next = S_A_RD;
        end
      end
      S_GROW: begin
        if (flags.grow_ok) begin
          cmd.op     = OP_GROW;
          state_next = S_G_CHK;
        end else begin
          cmd.op     = OP_SET_RES;
          cmd.status = ST_FAIL;
          state_next = S_RESP;
        end
      end
      S_G_CHK: begin
        if (flags.grow_short) begin
          cmd.op     = OP_SET_RES;
          cmd.status = ST_FAIL;
          state_next = S_RESP;
        end else begin
          state_next = S_TAKE;
        end
      end
      S_TAKE: begin
        cmd.op     = OP_DECIDE;
        state_next = S_SH_CHK;
      end
      S_SH_CHK: begin
        priority if (!flags.split) begin
          state_next = S_WTAKE;
        end else if (flags.shift_done) begin
          state_next = S_SPLIT;
        end else begin
          cmd.op     = OP_SH_READ;
          state_next = S_SH_WR;
        end
      end
      S_SH_WR: begin
        cmd.op     = OP_SH_WRITE;
        state_next = S_SH_CHK;
      end
      S_SPLIT: begin
        cmd.op     = OP_SPLIT;
        state_next = S_WTAKE;
      end
      S_WTAKE: begin
        cmd.op     = OP_TAKE;
        state_next = S_RESP;
      end
      S_F_RD: begin
        if (flags.at_end) begin
          cmd.op     = OP_SET_RES;
          cmd.status = ST_UNKNOWN;
          state_next = S_RESP;
        end else begin
          cmd.op     = OP_READ;
          state_next = S_F_EV;
        end
      end
      S_F_EV: begin
        if (flags.addr_hit) begin
          cmd.op     = OP_MARK;
          state_next = S_M_RD;
        end else begin
          cmd.op     = OP_NEXT;
          state_next = S_F_RD;
        end
      end
      S_M_RD: begin
        if (flags.at_end) begin
          state_next = S_M_FIN;
        end else begin
          cmd.op     = OP_READ;
          state_next = S_M_EV;
        end
      end
      S_M_EV: begin
        cmd.op     = OP_MERGE;
        state_next = S_M_RD;
      end
      S_M_FIN: begin
        cmd.op     = OP_MFIN;
        state_next = S_RESP;
      end
      S_RESP: begin
        if (!flags.out_busy) begin
          cmd.op     = OP_PUSH;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: hdl/first_fit_heap_allocator_core.sv
`timescale 1ns / 1ps
// Channel  Signals                          Beat
// in       in_valid, in_ready, in_data      one request (req_t)
// out      out_valid, out_ready, out_data   one response (rsp_t)
// cfg      cfg_valid, cfg_ready, cfg_data   heap page limit
//
// An allocate scans the table entry by entry, each in a read and an evaluate state, and
// on a split shifts the later entries up one by one; a free scans the same way and then
// merges free runs in a pass over every entry. Reads of the block table are registered.
// Reset empties the table at once; no clearing pass is needed.
// A request is taken only when the previous one has been handed to the output register.
module first_fit_heap_allocator_core #(
  parameter int MAX_BLOCKS = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  ffha_pkg::req_t              in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output ffha_pkg::rsp_t              out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [ffha_pkg::PAGE_W-1:0] cfg_data
);
  import ffha_pkg::*;

  cmd_t   cmd;
  flags_t flags;

  assign cfg_ready = 1'b1;

  ffha_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .flags    (flags),
    .cmd      (cmd)
  );

  ffha_datapath #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (in_data),
    .cfg_we    (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .flags     (flags),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: verif/tb_first_fit_heap_allocator_core.sv
`timescale 1ns / 1ps
module tb_first_fit_heap_allocator_core;
  import ffha_pkg::*;

  localparam int NBLK = 64;
  localparam int HDR = 24;
  localparam int PGB = 4096;
  localparam longint CYCLE_LIMIT = 3000000;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  req_t in_data;
  logic out_valid;
  logic out_ready;
  rsp_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [PAGE_W-1:0] cfg_data;

  first_fit_heap_allocator_core #(.MAX_BLOCKS(NBLK)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  logic [27:0] blk_start [NBLK];
  logic [27:0] blk_bytes [NBLK];
  logic        blk_free  [NBLK];
  int          blk_cnt;
  longint      pages_used;
  longint      page_limit;

  rsp_t pending_rsp[$];
  logic [27:0] live_ptrs[$];
  int mismatches;
  longint cycles;
  int hold_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("first_fit_heap_allocator_core verification failed");
        $finish;
      end
    end
  end

  function automatic logic [27:0] take_entry(int idx, logic [27:0] asize);
    logic [27:0] rem;
    rem = blk_bytes[idx] - asize;
    if (rem > HDR + 8 && blk_cnt < NBLK) begin
      for (int k = blk_cnt; k > idx + 1; k--) begin
        blk_start[k] = blk_start[k-1];
        blk_bytes[k] = blk_bytes[k-1];
        blk_free[k] = blk_free[k-1];
      end
      blk_start[idx+1] = 28'(blk_start[idx] + 28'(HDR) + asize);
      blk_bytes[idx+1] = 28'(rem - 28'(HDR));
      blk_free[idx+1] = 1'b1;
      blk_bytes[idx] = asize;
      blk_cnt++;
    end
    blk_free[idx] = 1'b0;
    return 28'(blk_start[idx] + 28'(HDR));
  endfunction

  function automatic void merge_runs();
    int n;
    n = 0;
    for (int i = 0; i < blk_cnt; i++) begin
      if (n > 0 && blk_free[n-1] && blk_free[i]) begin
        blk_bytes[n-1] = 28'(blk_bytes[n-1] + 28'(HDR) + blk_bytes[i]);
      end else begin
        blk_start[n] = blk_start[i];
        blk_bytes[n] = blk_bytes[i];
        blk_free[n] = blk_free[i];
        n++;
      end
    end
    blk_cnt = n;
  endfunction

  function automatic rsp_t heap_response(req_t r);
    rsp_t o;
    logic [27:0] asize;
    longint pg, np;
    int i;
    o.result_offset = '0;
    o.status = ST_OK;
    if (r.req_type == REQ_ALLOC) begin
      if (r.req_size == 0) begin
        o.status = ST_FAIL;
        return o;
      end
      asize = (28'(r.req_size) + 28'd7) & ~28'd7;
      for (i = 0; i < blk_cnt; i++) begin
        if (blk_free[i] && blk_bytes[i] >= asize) begin
          o.result_offset = take_entry(i, asize);
          return o;
        end
      end
      pg = (longint'(asize) + HDR + PGB - 1) / PGB;
      if (pg == 0) pg = 1;
      np = pages_used + pg;
      if (blk_cnt >= NBLK || np > page_limit || np * PGB > 64'h1000_0000) begin
        o.status = ST_FAIL;
        return o;
      end
      i = blk_cnt;
      blk_start[i] = 28'(pages_used * PGB);
      blk_bytes[i] = 28'(pg * PGB - HDR);
      blk_free[i] = 1'b1;
      blk_cnt++;
      pages_used = np;
      if (blk_bytes[i] < asize) begin
        o.status = ST_FAIL;
        return o;
      end
      o.result_offset = take_entry(i, asize);
      return o;
    end
    if (r.payload_offset == 0) return o;
    for (i = 0; i < blk_cnt; i++) begin
      if (blk_start[i] + 28'(HDR) == r.payload_offset) begin
        blk_free[i] = 1'b1;
        merge_runs();
        return o;
      end
    end
    o.status = ST_UNKNOWN;
    return o;
  endfunction

  task automatic send_req(logic rtype, logic [23:0] size, logic [27:0] ptr);
    req_t r;
    rsp_t e;
    int gap;
    gap = $urandom_range(0, 19);
    if ($urandom_range(0, 3) == 0) gap = 0;
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    r.req_type = rtype;
    r.req_size = size;
    r.payload_offset = ptr;
    in_data <= r;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    e = heap_response(r);
    pending_rsp.push_back(e);
    if (rtype == REQ_ALLOC && e.status == ST_OK) live_ptrs.push_back(e.result_offset);
  endtask

  task automatic quiet_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic alloc_req(logic [23:0] size);
    send_req(REQ_ALLOC, size, 28'($urandom));
  endtask

  task automatic free_req(logic [27:0] ptr);
    send_req(REQ_FREE, 24'($urandom), ptr);
  endtask

  task automatic free_live();
    int k;
    logic [27:0] p;
    if (live_ptrs.size() == 0) begin
      free_req(28'd0);
      return;
    end
    k = $urandom_range(0, live_ptrs.size() - 1);
    p = live_ptrs[k];
    live_ptrs.delete(k);
    free_req(p);
  endtask

  task automatic drain();
    quiet_input();
    while (pending_rsp.size() != 0) @(negedge clk);
    repeat (600) @(negedge clk);
  endtask

  task automatic write_limit(longint v);
    drain();
    @(negedge clk);
    cfg_data <= PAGE_W'(v);
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    page_limit = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    rsp_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat %h", out_data);
      end else begin
        e = pending_rsp.pop_front();
        if (out_data.result_offset !== e.result_offset || out_data.status !== e.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected offset %h status %0d, got offset %h status %0d",
                     e.result_offset, e.status, out_data.result_offset, out_data.status);
        end
      end
    end
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        hold_cycles--;
      end else if (out_valid && !out_ready) begin
        if ($urandom_range(0, 2) != 0) repeat ($urandom_range(0, 19)) @(negedge clk);
        out_ready <= 1'b1;
      end else if (out_ready && out_valid) begin
        out_ready <= ($urandom_range(0, 3) != 0);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic test_directed();
    alloc_req(24'd0);
    free_req(28'd0);
    free_req(28'd5);
    alloc_req(24'd1);
    alloc_req(24'd8);
    alloc_req(24'd100);
    free_live();
    free_live();
    free_live();
    alloc_req(24'd4072);
    alloc_req(24'd4073);
    alloc_req(24'hFFFFFF);
    alloc_req(24'd16);
    free_req(live_ptrs.size() ? live_ptrs[0] : 28'd24);
    free_req(28'd24);
    free_req(28'hFFFFFFF);
    alloc_req(24'd40);
  endtask

  task automatic test_page_limits();
    write_limit(0);
    alloc_req(24'd10);
    alloc_req(24'd5000);
    write_limit(65536);
    alloc_req(24'hFFFFFF);
    alloc_req(24'hFFFFFF);
    alloc_req(24'd200000);
    while (live_ptrs.size() != 0) free_live();
    write_limit(2);
  endtask

  task automatic test_table_full();
    write_limit(131071);
    for (int i = 0; i < 70; i++) alloc_req(24'($urandom_range(1, 64)));
    alloc_req(24'd100);
    for (int i = 0; i < 20; i++) free_live();
    for (int i = 0; i < 20; i++) alloc_req(24'($urandom_range(1, 200)));
  endtask

  task automatic test_backpressure();
    hold_cycles = 3000;
    for (int i = 0; i < 6; i++) alloc_req(24'($urandom_range(1, 300)));
    quiet_input();
    while (hold_cycles > 0) @(negedge clk);
  endtask

  task automatic test_random(int n, longint lim);
    int c;
    write_limit(lim);
    for (int i = 0; i < n; i++) begin
      c = $urandom_range(0, 99);
      if (c < 45) begin
        if ($urandom_range(0, 9) == 0) alloc_req(24'($urandom));
        else alloc_req(24'($urandom_range(1, 3000)));
      end else if (c < 90) free_live();
      else if (c < 95) free_req(28'($urandom));
      else alloc_req(24'd0);
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    mismatches = 0;
    hold_cycles = 0;
    blk_cnt = 0;
    pages_used = 0;
    page_limit = 256;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_page_limits();
    test_table_full();
    test_backpressure();
    test_random(240, 256);
    test_random(240, 40);
    test_random(240, 131071);
    drain();
    if (mismatches == 0 && pending_rsp.size() == 0) begin
      $display("first_fit_heap_allocator_core verification clean");
    end else begin
      $display("first_fit_heap_allocator_core verification failed");
    end
    $finish;
  end

endmodule
